### sv/assert_macros.svh
// assertion macros used by text_word_tokenizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge out of reset
`define TWT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked in the cycle after the trigger
`define TWT_ASSERT_NEXT(label, clk, rstn, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error(msg);
`else
`define TWT_ASSERT(label, clk, rstn, prop, msg)
`define TWT_ASSERT_NEXT(label, clk, rstn, trig, prop, msg)
`endif

`endif

### sv/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg
// types, constants and helpers shared by the word tokenizer files
// ----------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

    localparam int unsigned TOKEN_LIMIT = 255;

    localparam logic [7:0] MAX_WORD_RESET   = 8'd255;
    localparam logic [7:0] MAX_NUMBER_RESET = 8'd4;

    typedef enum logic [1:0] {
        CASE_KEEP  = 2'd0,
        CASE_DOWN  = 2'd1,
        CASE_UP    = 2'd2,
        CASE_TITLE = 2'd3
    } case_mode_t;

    typedef enum logic [1:0] {
        REG_CASE_MODE  = 2'd0,
        REG_MAX_WORD   = 2'd1,
        REG_MAX_NUMBER = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef struct packed {
        case_mode_t case_mode;
        logic [7:0] max_word_length;
        logic [7:0] max_number_length;
    } twt_cfg_t;

    typedef struct packed {
        logic       in_word;
        logic       digits_only;
        logic [7:0] word_length;
    } twt_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
    } twt_result_t;

    localparam twt_state_t STATE_CLOSED = '{in_word: 1'b0, digits_only: 1'b1,
                                            word_length: 8'd0};

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= 8'h61) && (b <= 8'h7A);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b, input logic first,
                                        input case_mode_t mode);
        case_mode_t m;
        logic [7:0] r;
        m = mode;
        if (mode == CASE_TITLE)
        begin
            m = first ? CASE_UP : CASE_DOWN;
        end
        r = b;
        case (m)
            CASE_DOWN:
            begin
                if (is_upper(b))
                begin
                    r = b + 8'd32;
                end
            end
            CASE_UP:
            begin
                if (is_lower(b))
                begin
                    r = b - 8'd32;
                end
            end
            default:
            begin
                r = b;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/text_word_tokenizer.sv
// ----------------------------------------------------------------------------
// text_word_tokenizer
// splits a byte stream into case-folded word tokens
// ----------------------------------------------------------------------------
// One byte item is taken per clock cycle unless the output stalls; its result
// goes straight into the result register. Each item yields at most one result:
// a token character (tuser high) or a bare end-of-token mark (tuser low, tdata
// zero); tlast flags the last item of a token. Bytes that produce no result are
// absorbed without a bubble. The input keeps flowing while a result waits, as
// long as the result register is emptied in the same cycle. Registers are to
// be written through the cfg channel only while the stream is idle (unchecked).
`default_nettype none

module text_word_tokenizer
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tuser,   // [0] flush
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tuser,   // [0] has_char
    output logic            m_tlast,   // token_end
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    twt_pkg::twt_cfg_t    cfg_reg;
    twt_pkg::twt_cfg_t    cfg_next;
    twt_pkg::twt_state_t  state_reg;
    twt_pkg::twt_state_t  state_next;
    twt_pkg::twt_state_t  step_state;
    twt_pkg::twt_result_t step_result;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_char_reg;
    logic [7:0]           out_char_next;
    logic                 has_char_reg;
    logic                 has_char_next;
    logic                 token_end_reg;
    logic                 token_end_next;
    logic                 in_accept;
    logic                 bare_mark_ok;
    logic                 closed_ok;
    logic                 len_ok;
    logic                 flush_in;
    logic                 end_in;

    twt_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .in_byte    (s_tdata),
        .flush      (s_tuser),
        .state_next (step_state),
        .result     (step_result)
    );

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (twt_pkg::reg_index_t'(cfg_index))
                twt_pkg::REG_CASE_MODE:
                begin
                    cfg_next.case_mode = twt_pkg::case_mode_t'(cfg_data[1:0]);
                end
                twt_pkg::REG_MAX_WORD:
                begin
                    cfg_next.max_word_length = cfg_data;
                end
                twt_pkg::REG_MAX_NUMBER:
                begin
                    cfg_next.max_number_length = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        has_char_next  = has_char_reg;
        token_end_next = token_end_reg;
        if (in_accept)
        begin
            state_next = step_state;
            if (step_result.valid)
            begin
                out_valid_next = 1'b1;
                out_char_next  = step_result.out_char;
                has_char_next  = step_result.has_char;
                token_end_next = step_result.token_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.case_mode         <= twt_pkg::CASE_KEEP;
            cfg_reg.max_word_length   <= twt_pkg::MAX_WORD_RESET;
            cfg_reg.max_number_length <= twt_pkg::MAX_NUMBER_RESET;
            state_reg                 <= twt_pkg::STATE_CLOSED;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        has_char_reg  <= has_char_next;
        token_end_reg <= token_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = has_char_reg;
    assign m_tlast  = token_end_reg;

    assign bare_mark_ok = !(m_tvalid && !m_tuser) || (m_tlast && m_tdata == 8'd0);
    assign closed_ok    = state_reg.in_word
                       || (state_reg.digits_only && state_reg.word_length == 8'd0);
    assign len_ok       = {24'd0, state_reg.word_length} < twt_pkg::TOKEN_LIMIT;
    assign flush_in     = in_accept && s_tuser;
    assign end_in       = in_accept && step_result.valid && step_result.token_end;

`include "assert_macros.svh"

    // a mark without a character is always an end of token and carries zero
    `TWT_ASSERT(a_bare_mark, clk, rst_n, bare_mark_ok, "bare result must be a zero end mark")
    // a closed token holds no count and is reset to all digits
    `TWT_ASSERT(a_closed_state, clk, rst_n, closed_ok, "closed token state not cleared")
    // an open token never reaches the hard length limit
    `TWT_ASSERT(a_len_limit, clk, rst_n, len_ok, "token length beyond limit")
    // end of stream always leaves no open token
    `TWT_ASSERT_NEXT(a_flush_close, clk, rst_n, flush_in, !state_reg.in_word, "flush left a token open")
    // a token end always closes the token state
    `TWT_ASSERT_NEXT(a_end_close, clk, rst_n, end_in, !state_reg.in_word, "token end without closing")

endmodule

`default_nettype wire

### sv/twt_step.sv
// ----------------------------------------------------------------------------
// twt_step
// per-byte classification, case folding and token state update
// ----------------------------------------------------------------------------
`default_nettype none

module twt_step
(
    input  var twt_pkg::twt_cfg_t    cfg,
    input  var twt_pkg::twt_state_t  state,
    input  wire logic [7:0]          in_byte,
    input  wire logic                flush,
    output twt_pkg::twt_state_t      state_next,
    output twt_pkg::twt_result_t     result
);

    logic       digit;
    logic       alnum;
    logic       digits_next;
    logic [7:0] len;
    logic       limit_hit;

    assign digit       = twt_pkg::is_digit(in_byte);
    assign alnum       = digit || twt_pkg::is_upper(in_byte) || twt_pkg::is_lower(in_byte);
    assign digits_next = state.digits_only && digit;
    // word_length never exceeds TOKEN_LIMIT-1, so the count fits in 8 bits
    assign len         = state.word_length + 8'd1;
    assign limit_hit   = (len >= cfg.max_word_length)
                      || (digits_next && (len >= cfg.max_number_length))
                      || ({24'd0, len} >= twt_pkg::TOKEN_LIMIT);

    always_comb
    begin
        result     = '0;
        state_next = state;
        if (flush || !alnum)
        begin
            // separator or end of stream closes an open token
            result.valid     = state.in_word;
            result.token_end = 1'b1;
            state_next       = twt_pkg::STATE_CLOSED;
        end
        else if (state.in_word && state.digits_only && !digit)
        begin
            // letter after digits ends the number and is dropped
            result.valid     = 1'b1;
            result.token_end = 1'b1;
            state_next       = twt_pkg::STATE_CLOSED;
        end
        else
        begin
            result.valid     = 1'b1;
            result.has_char  = 1'b1;
            result.out_char  = twt_pkg::fold(in_byte, !state.in_word, cfg.case_mode);
            result.token_end = limit_hit;
            if (limit_hit)
            begin
                state_next = twt_pkg::STATE_CLOSED;
            end
            else
            begin
                state_next.in_word     = 1'b1;
                state_next.digits_only = digits_next;
                state_next.word_length = len;
            end
        end
    end

endmodule

`default_nettype wire
